// File: sv/akdh_pkg.sv
// Constants shared by the key depth hysteresis unit.
package akdh_pkg;

  localparam int DEF_ROWS        = 4;
  localparam int DEF_COLS        = 7;
  localparam int DEF_SAMPLE_BITS = 10;

  localparam int ROW_W     = 2;
  localparam int COL_W     = 3;
  localparam int DEPTH_W   = 8;
  localparam int CFG_W     = 8;
  localparam int CFG_IDX_W = 1;

  localparam logic [DEPTH_W-1:0] DEPTH_MAX   = 8'hFF;
  localparam logic [CFG_W-1:0]   PRESS_RST   = 8'd128;
  localparam logic [CFG_W-1:0]   RELEASE_RST = 8'd64;

  localparam logic [CFG_IDX_W-1:0] REG_PRESS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 1'd1;

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CAL    = 1'b1;

endpackage

// File: sv/analog_key_depth_hysteresis_unit.sv
// Calibrated key depth with press/release hysteresis for a key matrix.
//
// A calibration word stores the fully pressed and fully released converter
// levels of one key; it gives no result. A sample word is
// clamped to its key's range, scaled to depth 255*(v-lo)/(hi-lo) (0 when
// hi <= lo), and updates the key's pressed flag: a released key presses when
// depth > press_threshold, a pressed key releases when depth < release_threshold.
// A sample passes from acceptance to the result register in steps: the memory
// is read at the accept edge, then come clamp and scale, eight steps of the
// restoring divider (one quotient bit per cycle) and write-back; the next word
// is taken in the cycle after write-back, and a result that is not taken holds
// the unit in write-back. A word whose row or
// column lies outside the matrix is dropped in its accept cycle. Levels and
// pressed flags live in one single-port memory of ROWS*COLS entries; pressed
// flags read as released until a key's entry is first written. Sampling a key
// that was never calibrated gives an unspecified depth. Threshold registers
// may be written only while the unit is idle.
module analog_key_depth_hysteresis_unit #(
  parameter int ROWS        = akdh_pkg::DEF_ROWS,
  parameter int COLS        = akdh_pkg::DEF_COLS,
  parameter int SAMPLE_BITS = akdh_pkg::DEF_SAMPLE_BITS
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [akdh_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [akdh_pkg::CFG_W-1:0]     cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           in_kind,
  input  logic [akdh_pkg::ROW_W-1:0]     in_key_row,
  input  logic [akdh_pkg::COL_W-1:0]     in_key_col,
  input  logic [SAMPLE_BITS-1:0]         in_sample,
  input  logic [SAMPLE_BITS-1:0]         in_cal_high,
  input  logic [SAMPLE_BITS-1:0]         in_cal_low,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [akdh_pkg::ROW_W-1:0]     out_row,
  output logic [akdh_pkg::COL_W-1:0]     out_col,
  output logic [akdh_pkg::DEPTH_W-1:0]   out_depth,
  output logic                           out_pressed
);
  import akdh_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int NKEYS = ROWS * COLS;
  localparam int KEY_W = (NKEYS > 1) ? $clog2(NKEYS) : 1;
  localparam int ENT_W = 2 * SB + 1;
  localparam int NUM_W = SB + DEPTH_W;
  localparam int CNT_W = $clog2(DEPTH_W);

  localparam logic [4:0] ROWS_L = 5'(ROWS);
  localparam logic [4:0] COLS_L = 5'(COLS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_DONE = 3'd3;

  logic [2:0]             state_r, state_nxt;
  logic [CFG_W-1:0]       press_r, release_r;
  logic                   kind_r;
  logic [KEY_W-1:0]       key_r;
  logic [ROW_W-1:0]       row_r;
  logic [COL_W-1:0]       col_r;
  logic [SB-1:0]          sample_r, cal_hi_r, cal_lo_r;
  logic [SB-1:0]          den_r, rem_r;
  logic [DEPTH_W-1:0]     quo_r;
  logic [CNT_W-1:0]       cnt_r;
  logic                   empty_r;
  logic [NKEYS-1:0]       vld_r;
  logic [ENT_W-1:0]       mem [NKEYS];
  logic [ENT_W-1:0]       rdata_r;
  logic                   out_valid_r, out_pressed_r;
  logic [ROW_W-1:0]       out_row_r;
  logic [COL_W-1:0]       out_col_r;
  logic [DEPTH_W-1:0]     out_depth_r;

  logic                   in_acc, in_range;
  logic [KEY_W-1:0]       in_key;
  logic [SB-1:0]          rd_hi, rd_lo, v_clamp, span_x;
  logic                   rd_empty, pflag_cur, pflag_new, done_go;
  logic [NUM_W-1:0]       num;
  logic [SB:0]            trial, diff;
  logic                   ge;
  logic [DEPTH_W-1:0]     depth_fin;
  logic                   mem_we;
  logic [ENT_W-1:0]       mem_wdata;

  assign in_ready = (state_r == ST_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign in_range = ({3'b000, in_key_row} < ROWS_L) && ({2'b00, in_key_col} < COLS_L);
  assign in_key   = KEY_W'(KEY_W'(in_key_row) * KEY_W'(COLS) + KEY_W'(in_key_col));

  assign rd_hi     = rdata_r[2*SB-1:SB];
  assign rd_lo     = rdata_r[SB-1:0];
  assign rd_empty  = (rd_hi <= rd_lo);
  assign pflag_cur = vld_r[key_r] && rdata_r[2*SB];

  always_comb begin
    if (sample_r > rd_hi) begin
      v_clamp = rd_hi;
    end else if (sample_r < rd_lo) begin
      v_clamp = rd_lo;
    end else begin
      v_clamp = sample_r;
    end
  end

  assign span_x = v_clamp - rd_lo;
  assign num    = {span_x, {DEPTH_W{1'b0}}} - {{DEPTH_W{1'b0}}, span_x};

  assign trial = {rem_r, quo_r[DEPTH_W-1]};
  assign ge    = (trial >= {1'b0, den_r});
  assign diff  = trial - {1'b0, den_r};

  assign depth_fin = empty_r ? '0 : quo_r;

  always_comb begin
    pflag_new = pflag_cur;
    if (!pflag_cur && (depth_fin > press_r)) begin
      pflag_new = 1'b1;
    end else if (pflag_cur && (depth_fin < release_r)) begin
      pflag_new = 1'b0;
    end
  end

  assign done_go = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign mem_we  = ((state_r == ST_LOAD) && (kind_r == KIND_CAL)) || done_go;

  always_comb begin
    if (kind_r == KIND_CAL) begin
      mem_wdata = {pflag_cur, cal_hi_r, cal_lo_r};
    end else begin
      mem_wdata = {pflag_new, rd_hi, rd_lo};
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_acc && in_range) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        state_nxt = (kind_r == KIND_CAL) ? ST_IDLE : ST_DIV;
      end
      ST_DIV: begin
        if (cnt_r == CNT_W'(DEPTH_W - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (done_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      press_r     <= PRESS_RST;
      release_r   <= RELEASE_RST;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_PRESS:   press_r   <= cfg_data;
          REG_RELEASE: release_r <= cfg_data;
          default: begin
          end
        endcase
      end
      if (mem_we) begin
        vld_r[key_r] <= 1'b1;
      end
      if (done_go) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[key_r] <= mem_wdata;
    end
    if (in_acc && in_range) begin
      rdata_r <= mem[in_key];
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      kind_r   <= in_kind;
      key_r    <= in_key;
      row_r    <= in_key_row;
      col_r    <= in_key_col;
      sample_r <= in_sample;
      cal_hi_r <= in_cal_high;
      cal_lo_r <= in_cal_low;
    end
    case (state_r)
      ST_LOAD: begin
        den_r   <= rd_hi - rd_lo;
        rem_r   <= num[NUM_W-1:DEPTH_W];
        quo_r   <= num[DEPTH_W-1:0];
        empty_r <= rd_empty;
        cnt_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= ge ? diff[SB-1:0] : trial[SB-1:0];
        quo_r <= {quo_r[DEPTH_W-2:0], ge};
        cnt_r <= cnt_r + CNT_W'(1);
      end
      default: begin
      end
    endcase
    if (done_go) begin
      out_row_r     <= row_r;
      out_col_r     <= col_r;
      out_depth_r   <= depth_fin;
      out_pressed_r <= pflag_new;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_row     = out_row_r;
  assign out_col     = out_col_r;
  assign out_depth   = out_depth_r;
  assign out_pressed = out_pressed_r;

`ifndef SYNTHESIS
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_DONE)
    else $error("result word raised outside write-back");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) && (cnt_r == CNT_W'(DEPTH_W - 1)) |=> state_r == ST_DONE)
    else $error("divider did not finish after last quotient bit");

  a_drop_range: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_range |=> state_r == ST_IDLE)
    else $error("out-of-matrix word was not dropped");

  a_we_state: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (state_r == ST_LOAD) || (state_r == ST_DONE))
    else $error("memory write outside load or write-back");

  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    done_go && empty_r |=> out_depth_r == '0)
    else $error("empty calibration range gave nonzero depth");
`endif

endmodule

// File: verif/tb_analog_key_depth_hysteresis_unit.sv
// Self-checking testbench for the calibrated key depth hysteresis unit.
module tb_analog_key_depth_hysteresis_unit;
  import akdh_pkg::*;

  localparam int NROWS = DEF_ROWS;
  localparam int NCOLS = DEF_COLS;
  localparam int SBITS = DEF_SAMPLE_BITS;
  localparam int NKEYS = NROWS * NCOLS;

  typedef struct packed {
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [DEPTH_W-1:0] depth;
    logic               pressed;
  } key_result_t;

  class key_depth_scoreboard;
    logic [CFG_W-1:0] press_thr = PRESS_RST;
    logic [CFG_W-1:0] release_thr = RELEASE_RST;
    logic [SBITS-1:0] level_hi[NKEYS];
    logic [SBITS-1:0] level_lo[NKEYS];
    logic             key_down[NKEYS];
    key_result_t      expected_q[$];
    int               errors = 0;

    function void clear_keys();
      foreach (key_down[k]) key_down[k] = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_PRESS) press_thr = val;
      else if (idx == REG_RELEASE) release_thr = val;
    endfunction

    function logic [DEPTH_W-1:0] scaled_depth(int unsigned v, int unsigned lo,
                                              int unsigned hi);
      if (hi <= lo) return '0;
      if (v > hi) v = hi;
      if (v < lo) v = lo;
      return DEPTH_W'((int'(DEPTH_MAX) * (v - lo)) / (hi - lo));
    endfunction

    function void note_word(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                            logic [SBITS-1:0] smp, logic [SBITS-1:0] hi,
                            logic [SBITS-1:0] lo);
      int          key;
      key_result_t res;
      if (row >= NROWS || col >= NCOLS) return;
      key = row * NCOLS + col;
      if (kind == KIND_CAL) begin
        level_hi[key] = hi;
        level_lo[key] = lo;
        return;
      end
      res.row   = row;
      res.col   = col;
      res.depth = scaled_depth(32'(smp), 32'(level_lo[key]), 32'(level_hi[key]));
      if (!key_down[key] && res.depth > press_thr) key_down[key] = 1'b1;
      else if (key_down[key] && res.depth < release_thr) key_down[key] = 1'b0;
      res.pressed = key_down[key];
      expected_q.push_back(res);
    endfunction

    task flag_mismatch(string what, int got, int want);
      $display("MISMATCH %s: got %0d expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(key_result_t got);
      key_result_t want;
      if (expected_q.size() == 0) begin
        flag_mismatch("unexpected word, row", int'(got.row), -1);
        return;
      end
      want = expected_q.pop_front();
      if (got.row != want.row) flag_mismatch("row", int'(got.row), int'(want.row));
      if (got.col != want.col) flag_mismatch("col", int'(got.col), int'(want.col));
      if (got.depth != want.depth) begin
        flag_mismatch("depth", int'(got.depth), int'(want.depth));
      end
      if (got.pressed != want.pressed) begin
        flag_mismatch("pressed", int'(got.pressed), int'(want.pressed));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_kind;
  logic [ROW_W-1:0]     in_key_row;
  logic [COL_W-1:0]     in_key_col;
  logic [SBITS-1:0]     in_sample;
  logic [SBITS-1:0]     in_cal_high;
  logic [SBITS-1:0]     in_cal_low;
  logic                 out_valid;
  logic                 out_ready;
  logic [ROW_W-1:0]     out_row;
  logic [COL_W-1:0]     out_col;
  logic [DEPTH_W-1:0]   out_depth;
  logic                 out_pressed;

  key_depth_scoreboard sb;
  int                  results_seen = 0;
  int                  hold_left = 0;
  int                  next_hold = 400;
  int                  rx_cyc = 0;
  logic [SBITS-1:0]    stim_hi[NKEYS];
  logic [SBITS-1:0]    stim_lo[NKEYS];

  analog_key_depth_hysteresis_unit u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_kind     (in_kind),
    .in_key_row  (in_key_row),
    .in_key_col  (in_key_col),
    .in_sample   (in_sample),
    .in_cal_high (in_cal_high),
    .in_cal_low  (in_cal_low),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_row     (out_row),
    .out_col     (out_col),
    .out_depth   (out_depth),
    .out_pressed (out_pressed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("analog_key_depth_hysteresis_unit verification failed");
    $finish;
  end

  // Receiver: rotate through stall patterns, with long hold-offs to back up the input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (results_seen >= next_hold) begin
        out_ready <= 1'b0;
        hold_left = 400;
        next_hold += 700;
      end else begin
        case ((rx_cyc / 150) % 4)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= ($urandom_range(0, 3) == 0);
          default: out_ready <= ($urandom_range(0, 7) != 0);
        endcase
      end
      rx_cyc++;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_result('{row: out_row, col: out_col, depth: out_depth,
                        pressed: out_pressed});
      results_seen++;
    end
  end

  task automatic send_word(logic kind, logic [ROW_W-1:0] row, logic [COL_W-1:0] col,
                           logic [SBITS-1:0] smp, logic [SBITS-1:0] hi,
                           logic [SBITS-1:0] lo);
    @(negedge clk);
    in_valid    <= 1'b1;
    in_kind     <= kind;
    in_key_row  <= row;
    in_key_col  <= col;
    in_sample   <= smp;
    in_cal_high <= hi;
    in_cal_low  <= lo;
    do @(posedge clk); while (!in_ready);
    sb.note_word(kind, row, col, smp, hi, lo);
  endtask

  task automatic pause_input(int n);
    if (n == 0) return;
    @(negedge clk);
    in_valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic settle();
    pause_input(1);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic calibrate_random(int key);
    logic [SBITS-1:0] hi;
    logic [SBITS-1:0] lo;
    int               pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) begin
      hi = SBITS'($urandom_range(0, 1023));
      lo = SBITS'($urandom_range(hi, 1023));
    end else if (pick == 1) begin
      hi = '1;
      lo = '0;
    end else begin
      lo = SBITS'($urandom_range(0, 600));
      hi = SBITS'($urandom_range(lo + 1, 1023));
    end
    stim_hi[key] = hi;
    stim_lo[key] = lo;
    send_word(KIND_CAL, ROW_W'(key / NCOLS), COL_W'(key % NCOLS), SBITS'($urandom),
              hi, lo);
  endtask

  task automatic random_word();
    int               pick;
    int               key;
    logic [SBITS-1:0] smp;
    pick = $urandom_range(0, 99);
    key  = $urandom_range(0, NKEYS - 1);
    if (pick < 8) begin
      calibrate_random(key);
    end else if (pick < 13) begin
      send_word(1'($urandom), ROW_W'($urandom), 3'd7, SBITS'($urandom),
                SBITS'($urandom), SBITS'($urandom));
    end else begin
      if (pick < 55 || stim_hi[key] <= stim_lo[key]) smp = SBITS'($urandom);
      else smp = SBITS'($urandom_range(stim_lo[key], stim_hi[key]));
      send_word(KIND_SAMPLE, ROW_W'(key / NCOLS), COL_W'(key % NCOLS), smp,
                SBITS'($urandom), SBITS'($urandom));
    end
  endtask

  initial begin
    logic [CFG_W-1:0] press_set[7];
    logic [CFG_W-1:0] release_set[7];
    int               burst_left;
    sb = new;
    sb.clear_keys();
    press_set   = '{8'd0, 8'd255, 8'd255, 8'd0, 8'd200, 8'd0, 8'd100};
    release_set = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd30, 8'd0, 8'd150};
    press_set[5]   = CFG_W'($urandom);
    release_set[5] = CFG_W'($urandom);
    burst_left = 0;
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_PRESS;
    cfg_data    = '0;
    in_valid    = 1'b0;
    in_kind     = KIND_SAMPLE;
    in_key_row  = '0;
    in_key_col  = '0;
    in_sample   = '0;
    in_cal_high = '0;
    in_cal_low  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_word(KIND_CAL, 0, 0, 0, 1023, 0);
    send_word(KIND_SAMPLE, 0, 0, 0, 0, 0);
    send_word(KIND_SAMPLE, 0, 0, 1023, 0, 0);
    send_word(KIND_SAMPLE, 0, 0, 512, 0, 0);
    send_word(KIND_SAMPLE, 0, 0, 100, 0, 0);
    send_word(KIND_SAMPLE, 0, 0, 300, 0, 0);
    send_word(KIND_CAL, 3, 6, 0, 0, 1023);
    send_word(KIND_SAMPLE, 3, 6, 1023, 0, 0);
    send_word(KIND_CAL, 3, 6, 0, 512, 512);
    send_word(KIND_SAMPLE, 3, 6, 512, 0, 0);
    send_word(KIND_CAL, 3, 7, 0, 1023, 1023);
    send_word(KIND_SAMPLE, 3, 7, 700, 0, 0);
    send_word(KIND_SAMPLE, 0, 7, 0, 0, 0);
    send_word(KIND_CAL, 2, 5, 0, 900, 100);
    send_word(KIND_SAMPLE, 2, 5, 50, 0, 0);
    send_word(KIND_SAMPLE, 2, 5, 1000, 0, 0);
    send_word(KIND_SAMPLE, 2, 5, 500, 0, 0);
    send_word(KIND_SAMPLE, 2, 5, 100, 0, 0);
    send_word(KIND_CAL, 1, 3, 0, 1023, 1022);
    send_word(KIND_SAMPLE, 1, 3, 1023, 0, 0);
    send_word(KIND_SAMPLE, 1, 3, 0, 0, 0);
    send_word(KIND_CAL, 1, 2, 0, 255, 0);
    send_word(KIND_SAMPLE, 1, 2, 128, 0, 0);
    send_word(KIND_SAMPLE, 1, 2, 129, 0, 0);
    send_word(KIND_SAMPLE, 1, 2, 64, 0, 0);
    send_word(KIND_SAMPLE, 1, 2, 63, 0, 0);
    settle();

    for (int k = 0; k < NKEYS; k++) calibrate_random(k);
    for (int ph = 0; ph < 7; ph++) begin
      settle();
      write_reg(REG_PRESS, press_set[ph]);
      write_reg(REG_RELEASE, release_set[ph]);
      for (int n = 0; n < 250; n++) begin
        if (burst_left == 0) begin
          pause_input(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 14));
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 90)
                                                   : $urandom_range(1, 24);
        end
        random_word();
        burst_left--;
      end
    end

    settle();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("analog_key_depth_hysteresis_unit verification clean");
    end else begin
      $display("analog_key_depth_hysteresis_unit verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
sv/akdh_pkg.sv
sv/analog_key_depth_hysteresis_unit.sv
verif/tb_analog_key_depth_hysteresis_unit.sv
